// ===== rtl/rpip_pkg.sv =====
// Package with the shared types, codes and character constants of the integer parser.
`timescale 1ns / 1ps
`default_nettype none

package rpip_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int CH_BITS        = 8;
    localparam int OUT_BITS       = 32;
    localparam int DIGIT_BITS     = 5;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SIGNED = 2'd1;
    localparam logic [1:0] PH_ZERO   = 2'd2;
    localparam logic [1:0] PH_DIGITS = 2'd3;

    localparam logic [1:0] RDX_DEC = 2'd0;
    localparam logic [1:0] RDX_HEX = 2'd1;
    localparam logic [1:0] RDX_OCT = 2'd2;
    localparam logic [1:0] RDX_BIN = 2'd3;

    localparam logic [CH_BITS-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_BITS-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CH_BITS-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_BITS-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_BITS-1:0] CH_UP_A   = 8'h41;
    localparam logic [CH_BITS-1:0] CH_UP_F   = 8'h46;
    localparam logic [CH_BITS-1:0] CH_LO_A   = 8'h61;
    localparam logic [CH_BITS-1:0] CH_LO_F   = 8'h66;
    localparam logic [CH_BITS-1:0] CH_LO_X   = 8'h78;
    localparam logic [CH_BITS-1:0] CH_LO_O   = 8'h6F;
    localparam logic [CH_BITS-1:0] CH_LO_B   = 8'h62;
    localparam logic [CH_BITS-1:0] CASE_BIT  = 8'h20;

    localparam logic [DIGIT_BITS-1:0] NO_DIGIT = 5'd16;

    typedef struct packed {
        logic [1:0] phase;
        logic       negative;
        logic [1:0] radix;
        logic       failed;
    } ctl_t;

    localparam ctl_t CTL_RESET = '{phase: PH_FIRST, negative: 1'b0, radix: RDX_DEC,
                                   failed: 1'b0};

    // Value of a hexadecimal digit character, or NO_DIGIT for any other character.
    function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [CH_BITS-1:0] c);
        logic [DIGIT_BITS-1:0] d;
        begin
            d = NO_DIGIT;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                d = DIGIT_BITS'(c - CH_ZERO);
            end
            else if (c >= CH_UP_A && c <= CH_UP_F)
            begin
                d = DIGIT_BITS'(c - CH_UP_A + 8'd10);
            end
            else if (c >= CH_LO_A && c <= CH_LO_F)
            begin
                d = DIGIT_BITS'(c - CH_LO_A + 8'd10);
            end
            return d;
        end
    endfunction

    function automatic logic [DIGIT_BITS-1:0] base_of(input logic [1:0] r);
        logic [DIGIT_BITS-1:0] b;
        begin
            case (r)
                RDX_HEX: b = 5'd16;
                RDX_OCT: b = 5'd8;
                RDX_BIN: b = 5'd2;
                default: b = 5'd10;
            endcase
            return b;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rpip_step.sv =====
// Next-state logic of the parser for one character: prefix decode, digit check and accumulate.
`timescale 1ns / 1ps
`default_nettype none

module rpip_step #(
    parameter int VALUE_BITS = rpip_pkg::VALUE_BITS_DEF
) (
    input  rpip_pkg::ctl_t                ctl,
    input  logic [VALUE_BITS-1:0]         accum,
    input  logic [rpip_pkg::CH_BITS-1:0]  ch,
    input  logic                          last,
    output rpip_pkg::ctl_t                ctl_next,
    output logic [VALUE_BITS-1:0]         accum_next
);
    import rpip_pkg::*;

    logic [1:0]            dig_radix;
    logic [DIGIT_BITS-1:0] digit;
    logic                  digit_ok;
    logic [VALUE_BITS-1:0] scaled;
    logic [VALUE_BITS-1:0] sum;
    logic [CH_BITS-1:0]    lower;
    logic                  is_sign;

    // In the first positions a nonzero digit always starts a decimal number.
    assign dig_radix = (ctl.phase == PH_FIRST || ctl.phase == PH_SIGNED) ? RDX_DEC : ctl.radix;
    assign digit     = digit_of(ch);
    assign digit_ok  = digit < base_of(dig_radix);
    assign lower     = ch | CASE_BIT;
    assign is_sign   = (ch == CH_PLUS) || (ch == CH_MINUS);

    always_comb
    begin
        case (dig_radix)
            RDX_HEX: scaled = accum << 4;
            RDX_OCT: scaled = accum << 3;
            RDX_BIN: scaled = accum << 1;
            default: scaled = (accum << 3) + (accum << 1);
        endcase
    end

    assign sum = scaled + {{(VALUE_BITS - 4){1'b0}}, digit[3:0]};

    always_comb
    begin
        ctl_next   = ctl;
        accum_next = accum;
        if (!ctl.failed)
        begin
            case (ctl.phase)
                PH_FIRST, PH_SIGNED:
                begin
                    if (ctl.phase == PH_FIRST && is_sign)
                    begin
                        ctl_next.negative = (ch == CH_MINUS);
                        ctl_next.phase    = PH_SIGNED;
                        ctl_next.failed   = last;
                    end
                    else if (ch == CH_ZERO)
                    begin
                        ctl_next.radix = RDX_OCT;
                        ctl_next.phase = PH_ZERO;
                    end
                    else
                    begin
                        ctl_next.radix = RDX_DEC;
                        ctl_next.phase = PH_DIGITS;
                        if (digit_ok)
                        begin
                            accum_next = sum;
                        end
                        else
                        begin
                            ctl_next.failed = 1'b1;
                        end
                    end
                end
                PH_ZERO:
                begin
                    ctl_next.phase = PH_DIGITS;
                    if (lower == CH_LO_X)
                    begin
                        ctl_next.radix = RDX_HEX;
                    end
                    else if (lower == CH_LO_O)
                    begin
                        ctl_next.radix = RDX_OCT;
                    end
                    else if (lower == CH_LO_B)
                    begin
                        ctl_next.radix = RDX_BIN;
                    end
                    else if (digit_ok)
                    begin
                        accum_next = sum;
                    end
                    else
                    begin
                        ctl_next.failed = 1'b1;
                    end
                end
                default:
                begin
                    if (digit_ok)
                    begin
                        accum_next = sum;
                    end
                    else
                    begin
                        ctl_next.failed = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/radix_prefixed_integer_parser.sv =====
// Top level of the radix-prefixed integer parser: token state, finish stage and result register.
// Throughput: one character per cycle while in_ready is high; in_ready drops when the finish stage holds
// a result that cannot advance. A token's result passes the finish register, then the result register.
// The digit check and the shift-add accumulate set the per-character path; the sign is
// applied in a separate finish stage ahead of the result register.
// Reset (rst_n low, asynchronous) clears the parse state and empties both result stages.
`timescale 1ns / 1ps
`default_nettype none

module radix_prefixed_integer_parser #(
    parameter int VALUE_BITS = rpip_pkg::VALUE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [rpip_pkg::CH_BITS-1:0]         ch,
    input  logic                                 last,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [rpip_pkg::OUT_BITS-1:0] value,
    output logic                                 bad
);
    import rpip_pkg::*;

    ctl_t                         ctl_reg;
    ctl_t                         ctl_next;
    logic [VALUE_BITS-1:0]        accum_reg;
    logic [VALUE_BITS-1:0]        accum_next;

    logic                         fin_valid_reg;
    logic                         fin_neg_reg;
    logic                         fin_bad_reg;
    logic [VALUE_BITS-1:0]        fin_accum_reg;

    logic                         out_valid_reg;
    logic [OUT_BITS-1:0]          value_reg;
    logic                         bad_reg;

    logic                         in_accept;
    logic                         fin_advance;
    logic [VALUE_BITS-1:0]        signed_accum;
    logic [VALUE_BITS+OUT_BITS-1:0] wide_accum;
    logic [OUT_BITS-1:0]          value_next;

    rpip_step #(
        .VALUE_BITS(VALUE_BITS)
    ) u_step (
        .ctl        (ctl_reg),
        .accum      (accum_reg),
        .ch         (ch),
        .last       (last),
        .ctl_next   (ctl_next),
        .accum_next (accum_next)
    );

    assign fin_advance = !out_valid_reg || out_ready;
    assign in_ready    = !fin_valid_reg || fin_advance;
    assign in_accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg   <= CTL_RESET;
            accum_reg <= '0;
        end
        else if (in_accept)
        begin
            if (last)
            begin
                ctl_reg   <= CTL_RESET;
                accum_reg <= '0;
            end
            else
            begin
                ctl_reg   <= ctl_next;
                accum_reg <= accum_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (in_accept && last)
        begin
            fin_valid_reg <= 1'b1;
        end
        else if (fin_advance)
        begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && last)
        begin
            fin_neg_reg   <= ctl_next.negative;
            fin_bad_reg   <= ctl_next.failed;
            fin_accum_reg <= accum_next;
        end
    end

    // The result keeps the low bits of the wrapped value, zero-filled when the value is narrower.
    assign signed_accum = fin_neg_reg ? ('0 - fin_accum_reg) : fin_accum_reg;
    assign wide_accum   = {{OUT_BITS{1'b0}}, signed_accum};
    assign value_next   = fin_bad_reg ? '0 : wide_accum[OUT_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_advance)
        begin
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_advance && fin_valid_reg)
        begin
            value_reg <= value_next;
            bad_reg   <= fin_bad_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign bad       = bad_reg;

endmodule

`default_nettype wire

// ===== bench/radix_prefixed_integer_parser_tb.sv =====
// Self-checking testbench for the radix-prefixed integer parser with a built-in predictor.
`timescale 1ns / 1ps

module radix_prefixed_integer_parser_tb;
    import rpip_pkg::*;

    localparam int NUM_DIRECTED = 27;
    localparam int RANDOM_ITEMS = 1900;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam logic [CH_BITS-1:0] CH_UP_Z = 8'h5A;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] value;
        logic                       bad;
    } result_t;

    typedef struct packed {
        logic [CH_BITS-1:0] ch;
        logic               last;
        logic               known;
        result_t            res;
    } row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [CH_BITS-1:0]         ch;
    logic                       last;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [OUT_BITS-1:0] value;
    logic                       bad;

    logic [1:0]          pr_phase;
    logic                pr_negative;
    logic [1:0]          pr_radix;
    logic [OUT_BITS-1:0] pr_accum;
    logic                pr_failed;

    result_t            pending_results[$];
    result_t            monitor_want;
    logic [CH_BITS-1:0] token_chars[$];
    logic               quiet;
    int                 mismatches;
    int                 items_sent;
    int                 tokens_sent;
    int                 results_seen;
    int                 bad_seen;
    int                 cycles;

    row_t directed_rows [NUM_DIRECTED] = '{
        '{CH_PLUS,           1'b1, 1'b1, '{32'sd0, 1'b1}},
        '{CH_MINUS,          1'b1, 1'b1, '{32'sd0, 1'b1}},
        '{CH_ZERO,           1'b1, 1'b1, '{32'sd0, 1'b0}},
        '{CH_MINUS,          1'b0, 1'b0, '{32'sd0, 1'b0}},
        '{CH_ZERO,           1'b1, 1'b1, '{32'sd0, 1'b0}},
        '{CH_ZERO,           1'b0, 1'b0, '{32'sd0, 1'b0}},
        '{CH_LO_X,           1'b1, 1'b1, '{32'sd0, 1'b0}},
        '{CH_ZERO,           1'b0, 1'b0, '{32'sd0, 1'b0}},
        '{CH_LO_B ^ CASE_BIT, 1'b1, 1'b1, '{32'sd0, 1'b0}},
        '{CH_ZERO,           1'b0, 1'b0, '{32'sd0, 1'b0}},
        '{CH_LO_O ^ CASE_BIT, 1'b0, 1'b0, '{32'sd0, 1'b0}},
        '{"1",               1'b0, 1'b0, '{32'sd0, 1'b0}},
        '{"7",               1'b1, 1'b0, '{32'sd0, 1'b0}},
        '{CH_NINE,           1'b1, 1'b1, '{32'sd9, 1'b0}},
        '{"1",               1'b0, 1'b0, '{32'sd0, 1'b0}},
        '{CH_MINUS,          1'b1, 1'b1, '{32'sd0, 1'b1}},
        '{CH_ZERO,           1'b0, 1'b0, '{32'sd0, 1'b0}},
        '{CH_LO_B,           1'b0, 1'b0, '{32'sd0, 1'b0}},
        '{"1",               1'b0, 1'b0, '{32'sd0, 1'b0}},
        '{CH_ZERO,           1'b0, 1'b0, '{32'sd0, 1'b0}},
        '{"2",               1'b1, 1'b1, '{32'sd0, 1'b1}},
        '{8'hFF,             1'b1, 1'b1, '{32'sd0, 1'b1}},
        '{8'h00,             1'b1, 1'b1, '{32'sd0, 1'b1}},
        '{CH_MINUS,          1'b0, 1'b0, '{32'sd0, 1'b0}},
        '{CH_ZERO,           1'b0, 1'b0, '{32'sd0, 1'b0}},
        '{CH_LO_X,           1'b0, 1'b0, '{32'sd0, 1'b0}},
        '{CH_LO_A,           1'b1, 1'b0, '{32'sd0, 1'b0}}
    };

    radix_prefixed_integer_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .bad       (bad)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 2);
        end
        else if (r < 95)
        begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    task automatic add_digit(input logic [CH_BITS-1:0] c);
        logic [4:0] digit;
        logic [4:0] base;
        digit = 5'd16;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            digit = 5'(c - CH_ZERO);
        end
        else if (c >= CH_UP_A && c <= CH_UP_F)
        begin
            digit = 5'(c - CH_UP_A) + 5'd10;
        end
        else if (c >= CH_LO_A && c <= CH_LO_F)
        begin
            digit = 5'(c - CH_LO_A) + 5'd10;
        end
        case (pr_radix)
            RDX_HEX: base = 5'd16;
            RDX_OCT: base = 5'd8;
            RDX_BIN: base = 5'd2;
            default: base = 5'd10;
        endcase
        if (digit >= base)
        begin
            pr_failed = 1'b1;
        end
        else
        begin
            pr_accum = pr_accum * 32'(base) + 32'(digit);
        end
    endtask

    task automatic start_body(input logic [CH_BITS-1:0] c);
        if (c == CH_ZERO)
        begin
            pr_accum = '0;
            pr_radix = RDX_OCT;
            pr_phase = PH_ZERO;
        end
        else
        begin
            pr_radix = RDX_DEC;
            pr_phase = PH_DIGITS;
            add_digit(c);
        end
    endtask

    task automatic parse_char(input logic [CH_BITS-1:0] c, input logic is_last,
                              output logic produced, output result_t res);
        logic [CH_BITS-1:0] lc;
        produced = 1'b0;
        res = '0;
        if (!pr_failed)
        begin
            case (pr_phase)
                PH_FIRST:
                begin
                    if (c == CH_PLUS || c == CH_MINUS)
                    begin
                        pr_negative = (c == CH_MINUS);
                        pr_phase = PH_SIGNED;
                        if (is_last)
                        begin
                            pr_failed = 1'b1;
                        end
                    end
                    else
                    begin
                        start_body(c);
                    end
                end
                PH_SIGNED:
                begin
                    start_body(c);
                end
                PH_ZERO:
                begin
                    lc = (c >= CH_UP_A && c <= CH_UP_Z) ? (c | CASE_BIT) : c;
                    pr_phase = PH_DIGITS;
                    if (lc == CH_LO_X)
                    begin
                        pr_radix = RDX_HEX;
                    end
                    else if (lc == CH_LO_O)
                    begin
                        pr_radix = RDX_OCT;
                    end
                    else if (lc == CH_LO_B)
                    begin
                        pr_radix = RDX_BIN;
                    end
                    else
                    begin
                        add_digit(c);
                    end
                end
                default:
                begin
                    add_digit(c);
                end
            endcase
        end
        if (is_last)
        begin
            produced = 1'b1;
            if (pr_failed)
            begin
                res.bad = 1'b1;
            end
            else
            begin
                res.value = pr_negative ? -pr_accum : pr_accum;
            end
            pr_phase = PH_FIRST;
            pr_negative = 1'b0;
            pr_radix = RDX_DEC;
            pr_accum = '0;
            pr_failed = 1'b0;
        end
    endtask

    task automatic send_char(input logic [CH_BITS-1:0] c, input logic is_last,
                             input logic known, input result_t known_res);
        int      gap;
        logic    produced;
        result_t res;
        gap = (!quiet && $urandom_range(0, 1) == 1) ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        ch = c;
        last = is_last;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        items_sent++;
        if (is_last)
        begin
            tokens_sent++;
        end
        parse_char(c, is_last, produced, res);
        if (produced)
        begin
            pending_results.push_back(known ? known_res : res);
        end
        @(negedge clk);
    endtask

    task automatic make_token();
        int                 kind;
        int                 ndig;
        int                 base_n;
        int                 d;
        int                 k;
        logic [CH_BITS-1:0] flip;
        token_chars.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 6)) token_chars.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind < 14)
        begin
            token_chars.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: token_chars.push_back(CH_PLUS);
                1: token_chars.push_back(CH_MINUS);
                default: ;
            endcase
            ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
            flip = $urandom_range(0, 1) ? CASE_BIT : 8'h00;
            base_n = 10;
            case ($urandom_range(0, 5))
                0:
                begin
                    token_chars.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
                end
                1:
                begin
                    token_chars.push_back(CH_ZERO);
                    token_chars.push_back(CH_LO_X ^ flip);
                    base_n = 16;
                end
                2:
                begin
                    token_chars.push_back(CH_ZERO);
                    token_chars.push_back(CH_LO_O ^ flip);
                    base_n = 8;
                end
                3:
                begin
                    token_chars.push_back(CH_ZERO);
                    token_chars.push_back(CH_LO_B ^ flip);
                    base_n = 2;
                end
                4:
                begin
                    token_chars.push_back(CH_ZERO);
                    base_n = 8;
                end
                default:
                begin
                    token_chars.push_back(CH_ZERO);
                    ndig = 0;
                end
            endcase
            for (k = 0; k < ndig; k++)
            begin
                d = $urandom_range(0, base_n - 1);
                if (d < 10)
                begin
                    token_chars.push_back(CH_ZERO + 8'(d));
                end
                else
                begin
                    token_chars.push_back(($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'(d - 10));
                end
            end
            if ($urandom_range(0, 6) == 0)
            begin
                token_chars[$urandom_range(0, token_chars.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end
    endtask

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                repeat (idle_len()) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (bad)
            begin
                bad_seen++;
            end
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no transaction pending", value, 32'd0);
            end
            else
            begin
                monitor_want = pending_results.pop_front();
                if (value !== monitor_want.value)
                begin
                    report_mismatch("value", value, monitor_want.value);
                end
                if (bad !== monitor_want.bad)
                begin
                    report_mismatch("bad", 32'(bad), 32'(monitor_want.bad));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results pending.", cycles,
                     pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int i;
        rst_n = 1'b0;
        in_valid = 1'b0;
        ch = '0;
        last = 1'b0;
        quiet = 1'b0;
        mismatches = 0;
        items_sent = 0;
        tokens_sent = 0;
        results_seen = 0;
        bad_seen = 0;
        cycles = 0;
        pr_phase = PH_FIRST;
        pr_negative = 1'b0;
        pr_radix = RDX_DEC;
        pr_accum = '0;
        pr_failed = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < NUM_DIRECTED; i++)
        begin
            send_char(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].known,
                      directed_rows[i].res);
        end

        while (items_sent < NUM_DIRECTED + RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                quiet = !quiet;
            end
            make_token();
            for (i = 0; i < token_chars.size(); i++)
            begin
                send_char(token_chars[i], i == token_chars.size() - 1, 1'b0, '0);
            end
        end
        in_valid = 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Parsed %0d tokens from %0d characters, mixing signs, all four radixes,",
                 tokens_sent, items_sent);
        $display("overflow and malformed input: %0d results checked, %0d flagged bad, %0d mismatches.",
                 results_seen, bad_seen, mismatches);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
